@@ design/qrp_pkg.sv @@
// shared types and constants of the qrp hash table builder
package qrp_pkg;

    localparam logic [31:0] HASH_MULT     = 32'h4F1B_BCDC;
    localparam logic [4:0]  MIN_SLOT_BITS = 5'd10;
    localparam logic [23:0] HASHED_MAX    = 24'hFF_FFFF;
    localparam int          ROW_BITS      = 6;

    localparam logic REQ_WORD  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam int          CFG_INDEX_W    = 4;
    localparam int          CFG_DATA_W     = 5;
    localparam logic [3:0]  CFG_TABLE_BITS = 4'd0;
    localparam logic [3:0]  CFG_FILL_CHECK = 4'd1;

    localparam logic [4:0]  TABLE_BITS_RESET = 5'd14;

    typedef struct packed {
        logic       req_type;
        logic [7:0] word_byte;
        logic       word_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] slot_index;
        logic        newly_filled;
        logic [16:0] filled_total;
        logic [23:0] hashed_total;
        logic        over_fill;
        logic        clear_done;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } t_cfg_item;

    typedef struct packed {
        logic byte_en;
        logic word_done;
        logic clear_req;
        logic hash;
        logic look;
        logic check;
        logic sweep;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic sweep_last;
    } t_ctrl_sts;

endpackage

@@ design/qrp_chan_if.sv @@
// valid/ready channel carrying one payload item per transfer
interface qrp_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/qrp_ctrl.sv @@
// controller state machine of the qrp hash table builder
module qrp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  qrp_pkg::t_in_item  i_in_item,
    input  qrp_pkg::t_ctrl_sts i_sts,
    output logic               o_in_ready,
    output qrp_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_LOOK  = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_needs_out;
    logic   w_take;

    assign w_needs_out = (i_in_item.req_type == qrp_pkg::REQ_CLEAR) || i_in_item.word_end;
    assign o_in_ready  = (r_state == S_IDLE) && (!w_needs_out || i_sts.out_free);
    assign w_take      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.byte_en   = w_take && (i_in_item.req_type == qrp_pkg::REQ_WORD);
        o_cmd.word_done = o_cmd.byte_en && i_in_item.word_end;
        o_cmd.clear_req = w_take && (i_in_item.req_type == qrp_pkg::REQ_CLEAR);
        o_cmd.hash      = (r_state == S_HASH);
        o_cmd.look      = (r_state == S_LOOK);
        o_cmd.check     = (r_state == S_CHECK);
        o_cmd.sweep     = (r_state == S_SWEEP);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd.clear_req) n_state = S_SWEEP;
                else if (o_cmd.word_done) n_state = S_HASH;
            end
            S_HASH:  n_state = S_LOOK;
            S_LOOK:  n_state = S_CHECK;
            S_CHECK: n_state = S_IDLE;
            default: n_state = S_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_SWEEP;
        else r_state <= n_state;
    end

endmodule

@@ design/qrp_dp.sv @@
// datapath: byte folding, hash multiply, presence table, counts and result register
module qrp_dp #(
    parameter int MAX_SLOT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qrp_pkg::t_ctrl_cmd i_cmd,
    input  qrp_pkg::t_in_item  i_in_item,
    input  logic               i_cfg_we,
    input  qrp_pkg::t_cfg_item i_cfg,
    input  logic               i_out_ready,
    output qrp_pkg::t_ctrl_sts o_sts,
    output logic               o_out_valid,
    output qrp_pkg::t_out_item o_out_item
);

    localparam int ROW_W    = 2 ** qrp_pkg::ROW_BITS;
    localparam int ADDR_W   = MAX_SLOT_BITS - qrp_pkg::ROW_BITS;
    localparam int ROWS     = 2 ** ADDR_W;
    localparam int FILL_W   = MAX_SLOT_BITS + 1;
    localparam int FIVE_W   = FILL_W + 3;

    logic [4:0]              r_table_bits;
    logic                    r_fill_check;
    logic [4:0]              w_bits;

    logic [31:0]             r_acc;
    logic [1:0]              r_pos;
    logic [7:0]              w_fold;
    logic [31:0]             n_acc;

    logic [31:0]             r_prod;
    logic [5:0]              w_shift;
    logic [31:0]             w_hash;
    logic [MAX_SLOT_BITS-1:0] w_idx;
    logic [MAX_SLOT_BITS-1:0] r_idx;

    logic [ROW_W-1:0]        r_mem [ROWS];
    logic [ROW_W-1:0]        r_rdata;
    logic [ADDR_W-1:0]       r_clr_row;

    logic [FILL_W-1:0]       r_filled;
    logic [FILL_W-1:0]       n_filled;
    logic [23:0]             r_hashed;
    logic [23:0]             n_hashed;
    logic                    w_newly;
    logic [ROW_W-1:0]        w_bit_mask;
    logic [FIVE_W-1:0]       w_five;
    logic [FIVE_W-1:0]       w_slots;
    logic                    w_over;

    logic                    r_out_valid;
    qrp_pkg::t_out_item      r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_bits <= qrp_pkg::TABLE_BITS_RESET;
            r_fill_check <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg.index == qrp_pkg::CFG_TABLE_BITS) r_table_bits <= i_cfg.value;
            else if (i_cfg.index == qrp_pkg::CFG_FILL_CHECK) r_fill_check <= i_cfg.value[0];
        end
    end

    always_comb begin
        if (r_table_bits < qrp_pkg::MIN_SLOT_BITS) w_bits = qrp_pkg::MIN_SLOT_BITS;
        else if (r_table_bits > 5'(MAX_SLOT_BITS)) w_bits = 5'(MAX_SLOT_BITS);
        else w_bits = r_table_bits;
    end

    // lower-case fold and rolling xor
    always_comb begin
        w_fold = i_in_item.word_byte;
        if (w_fold >= 8'h41 && w_fold <= 8'h5A) w_fold = w_fold + 8'h20;
        n_acc = r_acc ^ (32'(w_fold) << {r_pos, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_pos <= '0;
        end else if (i_cmd.clear_req) begin
            r_acc <= '0;
            r_pos <= '0;
        end else if (i_cmd.byte_en) begin
            r_acc <= n_acc;
            r_pos <= i_cmd.word_done ? 2'd0 : r_pos + 2'd1;
        end else if (i_cmd.hash) begin
            r_acc <= '0;
        end
    end

    // hash multiply and slot index
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash) r_prod <= r_acc * qrp_pkg::HASH_MULT;
    end

    assign w_shift = 6'd32 - {1'b0, w_bits};
    assign w_hash  = r_prod >> w_shift;
    assign w_idx   = w_hash[MAX_SLOT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) r_idx <= w_idx;
    end

    // presence table, one row per address
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) r_rdata <= r_mem[w_idx[MAX_SLOT_BITS-1:qrp_pkg::ROW_BITS]];
    end

    assign w_bit_mask = ROW_W'(1) << r_idx[qrp_pkg::ROW_BITS-1:0];
    assign w_newly    = ((r_rdata & w_bit_mask) == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) r_mem[r_clr_row] <= '0;
        else if (i_cmd.check)
            r_mem[r_idx[MAX_SLOT_BITS-1:qrp_pkg::ROW_BITS]] <= r_rdata | w_bit_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_row <= '0;
        else if (i_cmd.clear_req) r_clr_row <= '0;
        else if (i_cmd.sweep) r_clr_row <= r_clr_row + ADDR_W'(1);
    end

    // counts and over-fill
    assign n_filled = r_filled + FILL_W'(w_newly);
    assign n_hashed = (r_hashed == qrp_pkg::HASHED_MAX) ? r_hashed : r_hashed + 24'd1;
    assign w_five   = {n_filled, 2'b00} + FIVE_W'(n_filled);
    assign w_slots  = FIVE_W'(1) << w_bits;
    assign w_over   = r_fill_check && (w_five > w_slots);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_hashed <= '0;
        end else if (i_cmd.clear_req) begin
            r_filled <= '0;
            r_hashed <= '0;
        end else if (i_cmd.check) begin
            r_filled <= n_filled;
            r_hashed <= n_hashed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.clear_req || i_cmd.check) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_req) begin
            r_out <= '{slot_index: '0, newly_filled: 1'b0, filled_total: '0,
                       hashed_total: '0, over_fill: 1'b0, clear_done: 1'b1};
        end else if (i_cmd.check) begin
            r_out.slot_index   <= 16'(r_idx);
            r_out.newly_filled <= w_newly;
            r_out.filled_total <= 17'(n_filled);
            r_out.hashed_total <= n_hashed;
            r_out.over_fill    <= w_over;
            r_out.clear_done   <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.sweep_last = &r_clr_row;

endmodule

@@ design/qrp_hash_table_builder.sv @@
// top level of the qrp hash table builder
//
// i_in takes one item per transfer: a word byte (req_type 0, word_end on the
// last byte of a word) or a clear request (req_type 1). o_out returns one
// result per finished word and one per clear. i_cfg writes table_bits
// (index 0) and fill_check_enable (index 1); it is always ready.
// Non-final word bytes are taken one per cycle while the controller is idle.
// A final byte is taken only when the result register is free or draining;
// its result passes the hash, look and check states into the result register,
// and no further item is taken until those states are done, as set by the multiply
// register and the read-then-write of the presence table. A clear is answered
// in the cycle after its transfer, then the table is swept one 64-bit row per
// cycle over all 2**(MAX_SLOT_BITS-6) rows (1024 by default), taking no input.
// After reset the same sweep runs before the first input is taken;
// configuration writes are taken during it.
// When the receiver stalls, the result holds in the output register and
// word bytes keep flowing until the next final byte or clear.
module qrp_hash_table_builder #(
    parameter int MAX_SLOT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrp_chan_if.sink    i_in,
    qrp_chan_if.sink    i_cfg,
    qrp_chan_if.source  o_out
);

    qrp_pkg::t_ctrl_cmd w_cmd;
    qrp_pkg::t_ctrl_sts w_sts;
    qrp_pkg::t_in_item  w_in_item;
    qrp_pkg::t_cfg_item w_cfg_item;
    qrp_pkg::t_out_item w_out_item;
    logic               w_in_ready;
    logic               w_out_valid;

    assign w_in_item  = i_in.data;
    assign w_cfg_item = i_cfg.data;
    assign i_in.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_item;

    qrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_item  (w_in_item),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    qrp_dp #(
        .MAX_SLOT_BITS (MAX_SLOT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_item   (w_in_item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg       (w_cfg_item),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

`ifndef SYNTH
    a_word_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready && w_in_item.req_type == qrp_pkg::REQ_WORD &&
         w_in_item.word_end) |-> ##4 (w_out_valid && !w_out_item.clear_done))
        else $error("word result missing after final byte");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready && w_in_item.req_type == qrp_pkg::REQ_CLEAR)
        |=> (w_out_valid && w_out_item.clear_done))
        else $error("clear acknowledge missing");

    a_no_take_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.check || w_cmd.look || w_cmd.hash || w_cmd.sweep) |-> !w_in_ready)
        else $error("input taken during lookup or sweep");
`endif

endmodule
